FILE: src/fnh_pkg.sv
// Shared types and constants for the floating-point numeric hash core.
// Used by every module of the block; has no dependencies of its own.
`timescale 1ns / 1ps
package fnh_pkg;

	// Default width of the Mersenne modulus 2^HASH_BITS - 1.
	localparam int DEF_HASH_BITS = 61;

	// Word and binary64 field widths.
	localparam int WORD_W = 64;
	localparam int EXP_W  = 11;
	localparam int FRAC_W = 52;
	localparam int MANT_W = FRAC_W + 1;

	// Exponent of the integer mantissa is biased exponent minus this value.
	localparam int EXP_BIAS = 1075;

	// Exponent reduction: x = exponent field + offset, 12 bits hold it, and the
	// quotient by the modulus width comes from a scaled reciprocal.
	localparam int XW          = 12;
	localparam int RW          = 12;
	localparam int RECIP_SHIFT = 16;
	localparam int QW          = 8;

	// A result of all ones is replaced by this word (-2 in two's complement).
	localparam logic [WORD_W-1:0] HASH_NEG_TWO = {{(WORD_W-1){1'b1}}, 1'b0};

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NAN_HASH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INF_HASH = 1'b1;
	localparam logic [WORD_W-1:0] INF_HASH_RESET = 64'd314159;
	localparam logic [WORD_W-1:0] NAN_HASH_RESET = 64'd0;

	// Class of the input value.
	typedef enum logic [1:0] {
		CLS_FINITE = 2'b00,
		CLS_INF    = 2'b01,
		CLS_NAN    = 2'b10
	} fnh_class_t;

	// Control that travels alongside the data through the pipeline.
	typedef struct packed {
		logic       valid;
		fnh_class_t cls;
		logic       neg;
	} fnh_ctl_t;

endpackage

FILE: src/fnh_decode.sv
// Stage 1: unpacks the binary64 pattern and starts the exponent reduction.
// Depends on fnh_pkg.
`timescale 1ns / 1ps
module fnh_decode #(
	parameter int HASH_BITS = fnh_pkg::DEF_HASH_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fnh_pkg::WORD_W-1:0] value_bits,
	output fnh_pkg::fnh_ctl_t          ctl_s1,
	output logic [fnh_pkg::MANT_W-1:0] mant_s1,
	output logic [fnh_pkg::XW-1:0]     expx_s1,
	output logic [fnh_pkg::QW-1:0]     quot_s1
);

	localparam int EXP_OFF = (HASH_BITS - (fnh_pkg::EXP_BIAS % HASH_BITS)) % HASH_BITS;
	localparam int RECIP   = (1 << fnh_pkg::RECIP_SHIFT) / HASH_BITS;
	localparam int PW      = fnh_pkg::XW + fnh_pkg::RW;

	logic [fnh_pkg::EXP_W-1:0]  exp_field;
	logic [fnh_pkg::FRAC_W-1:0] frac;
	logic [fnh_pkg::EXP_W-1:0]  exp_eff;
	logic [fnh_pkg::XW-1:0]     expx;
	logic [PW-1:0]              prod;
	fnh_pkg::fnh_class_t        cls;

	assign exp_field = value_bits[fnh_pkg::WORD_W-2 -: fnh_pkg::EXP_W];
	assign frac      = value_bits[fnh_pkg::FRAC_W-1:0];

	// Subnormals share the exponent of the smallest normal.
	assign exp_eff = (exp_field == '0) ? fnh_pkg::EXP_W'(1) : exp_field;

	// Shifted so that x mod HASH_BITS equals the mantissa exponent mod HASH_BITS.
	assign expx = fnh_pkg::XW'(exp_eff) + fnh_pkg::XW'(EXP_OFF);

	// Estimated quotient is exact or one too small.
	assign prod = PW'(expx) * PW'(RECIP);

	always_comb begin
		if (exp_field != '1) begin
			cls = fnh_pkg::CLS_FINITE;
		end else if (frac != '0) begin
			cls = fnh_pkg::CLS_NAN;
		end else begin
			cls = fnh_pkg::CLS_INF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '{valid: 1'b0, cls: fnh_pkg::CLS_FINITE, neg: 1'b0};
		end else begin
			ctl_s1 <= '{valid: start, cls: cls, neg: value_bits[fnh_pkg::WORD_W-1]};
		end
	end

	always_ff @(posedge clk) begin
		mant_s1 <= {exp_field != '0, frac};
		expx_s1 <= expx;
		quot_s1 <= prod[fnh_pkg::RECIP_SHIFT +: fnh_pkg::QW];
	end

endmodule

FILE: src/fnh_reduce.sv
// Stage 2: folds the mantissa modulo the Mersenne prime and finishes the
// exponent remainder. Depends on fnh_pkg.
`timescale 1ns / 1ps
module fnh_reduce #(
	parameter int HASH_BITS = fnh_pkg::DEF_HASH_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fnh_pkg::fnh_ctl_t            ctl_s1,
	input  logic [fnh_pkg::MANT_W-1:0]   mant_s1,
	input  logic [fnh_pkg::XW-1:0]       expx_s1,
	input  logic [fnh_pkg::QW-1:0]       quot_s1,
	output fnh_pkg::fnh_ctl_t            ctl_s2,
	output logic [HASH_BITS-1:0]         fold_s2,
	output logic [$clog2(HASH_BITS)-1:0] rot_amt_s2
);

	localparam int EW = $clog2(HASH_BITS);

	logic [fnh_pkg::WORD_W-1:0] mant_w;
	logic [fnh_pkg::WORD_W-1:0] mant_hi_w;
	logic [HASH_BITS:0]         fold_sum;
	logic [HASH_BITS-1:0]       fold;
	logic [fnh_pkg::XW-1:0]     qh;
	logic [fnh_pkg::XW-1:0]     rem;
	logic [fnh_pkg::XW-1:0]     rem_c;

	// Mantissa mod 2^HASH_BITS - 1: add the high part to the low part.
	assign mant_w    = fnh_pkg::WORD_W'(mant_s1);
	assign mant_hi_w = mant_w >> HASH_BITS;
	assign fold_sum  = (HASH_BITS+1)'(mant_w[HASH_BITS-1:0]) +
		(HASH_BITS+1)'(mant_hi_w[HASH_BITS-1:0]);
	assign fold = (fold_sum >= (HASH_BITS+1)'({HASH_BITS{1'b1}})) ?
		HASH_BITS'(fold_sum - (HASH_BITS+1)'({HASH_BITS{1'b1}})) :
		HASH_BITS'(fold_sum);

	// Remainder from the estimated quotient, with one correction step.
	assign qh    = fnh_pkg::XW'(quot_s1) * fnh_pkg::XW'(HASH_BITS);
	assign rem   = expx_s1 - qh;
	assign rem_c = (rem >= fnh_pkg::XW'(HASH_BITS)) ? rem - fnh_pkg::XW'(HASH_BITS) : rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '{valid: 1'b0, cls: fnh_pkg::CLS_FINITE, neg: 1'b0};
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		fold_s2    <= fold;
		rot_amt_s2 <= EW'(rem_c);
	end

endmodule

FILE: src/fnh_finish.sv
// Stages 3 and 4: rotation by the exponent, sign handling and result select.
// Depends on fnh_pkg.
`timescale 1ns / 1ps
module fnh_finish #(
	parameter int HASH_BITS = fnh_pkg::DEF_HASH_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fnh_pkg::fnh_ctl_t            ctl_s2,
	input  logic [HASH_BITS-1:0]         fold_s2,
	input  logic [$clog2(HASH_BITS)-1:0] rot_amt_s2,
	input  logic [fnh_pkg::WORD_W-1:0]   nan_hash_q,
	input  logic [fnh_pkg::WORD_W-1:0]   inf_hash_q,
	output logic                         done_s4,
	output logic [fnh_pkg::WORD_W-1:0]   hash_s4
);

	fnh_pkg::fnh_ctl_t          ctl_s3;
	logic [HASH_BITS-1:0]       rot_s3;
	logic [2*HASH_BITS-1:0]     rot_dbl;
	logic [fnh_pkg::WORD_W-1:0] mag;
	logic [fnh_pkg::WORD_W-1:0] signed_val;
	logic [fnh_pkg::WORD_W-1:0] finite_val;
	logic [fnh_pkg::WORD_W-1:0] result;

	// Rotate left within HASH_BITS: upper half of the doubled word shifted.
	assign rot_dbl = {fold_s2, fold_s2} << rot_amt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '{valid: 1'b0, cls: fnh_pkg::CLS_FINITE, neg: 1'b0};
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		rot_s3 <= rot_dbl[2*HASH_BITS-1:HASH_BITS];
	end

	assign mag        = fnh_pkg::WORD_W'(rot_s3);
	assign signed_val = ctl_s3.neg ? fnh_pkg::WORD_W'(0) - mag : mag;
	assign finite_val = (signed_val == '1) ? fnh_pkg::HASH_NEG_TWO : signed_val;

	always_comb begin
		unique case (ctl_s3.cls)
			fnh_pkg::CLS_FINITE: result = finite_val;
			fnh_pkg::CLS_INF:    result = inf_hash_q;
			fnh_pkg::CLS_NAN:    result = nan_hash_q;
			default:             result = finite_val;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		hash_s4 <= result;
	end

endmodule

FILE: src/float_numeric_hash_mod_prime_core.sv
// Top level of the floating-point numeric hash core: configuration registers
// and the four-stage hash pipeline. Depends on fnh_pkg, fnh_decode,
// fnh_reduce and fnh_finish.
`timescale 1ns / 1ps
// Usage
// -----
// The block hashes IEEE binary64 bit patterns modulo the Mersenne prime
// 2^HASH_BITS - 1. A transaction is started by raising start with the pattern
// on value_bits; it is taken at any rising edge where start is high and busy
// is low. The pipeline never stalls, so busy stays low and a new value may be
// presented in every cycle: throughput is one transaction per clock.
// Each result appears on hash_word with done high for exactly one cycle. done
// rises once the transaction has passed the stage 1, 2 and 3 registers into
// the stage 4 register. Results leave in input order.
// The four stages are: unpack and exponent quotient estimate, mantissa fold and
// exponent remainder, rotation, and sign handling with the NaN/infinity select.
// The receiver cannot stall the output; it must take every done cycle.
// The configuration registers (NaN hash at index 0, infinity hash at index 1)
// are written through cfg_write/cfg_index/cfg_data with no wait, and should be
// changed only while no transaction is in flight.
// Asynchronous reset empties the pipeline and returns the registers to their
// reset values (0 for the NaN hash, 314159 for the infinity hash).
module float_numeric_hash_mod_prime_core #(
	parameter int HASH_BITS = fnh_pkg::DEF_HASH_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fnh_pkg::WORD_W-1:0]    value_bits,
	output logic                          done,
	output logic [fnh_pkg::WORD_W-1:0]    hash_word,
	input  logic                          cfg_write,
	input  logic [fnh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fnh_pkg::WORD_W-1:0]    cfg_data
);

	localparam int EW = $clog2(HASH_BITS);

	logic [fnh_pkg::WORD_W-1:0] nan_hash_q;
	logic [fnh_pkg::WORD_W-1:0] inf_hash_q;

	fnh_pkg::fnh_ctl_t          ctl_s1;
	logic [fnh_pkg::MANT_W-1:0] mant_s1;
	logic [fnh_pkg::XW-1:0]     expx_s1;
	logic [fnh_pkg::QW-1:0]     quot_s1;
	fnh_pkg::fnh_ctl_t          ctl_s2;
	logic [HASH_BITS-1:0]       fold_s2;
	logic [EW-1:0]              rot_amt_s2;

	// The pipeline takes a new transaction every cycle.
	assign busy = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nan_hash_q <= fnh_pkg::NAN_HASH_RESET;
			inf_hash_q <= fnh_pkg::INF_HASH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				fnh_pkg::REG_NAN_HASH: nan_hash_q <= cfg_data;
				fnh_pkg::REG_INF_HASH: inf_hash_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fnh_decode #(.HASH_BITS(HASH_BITS)) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start & ~busy),
		.value_bits (value_bits),
		.ctl_s1     (ctl_s1),
		.mant_s1    (mant_s1),
		.expx_s1    (expx_s1),
		.quot_s1    (quot_s1)
	);

	fnh_reduce #(.HASH_BITS(HASH_BITS)) u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.mant_s1    (mant_s1),
		.expx_s1    (expx_s1),
		.quot_s1    (quot_s1),
		.ctl_s2     (ctl_s2),
		.fold_s2    (fold_s2),
		.rot_amt_s2 (rot_amt_s2)
	);

	fnh_finish #(.HASH_BITS(HASH_BITS)) u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s2     (ctl_s2),
		.fold_s2    (fold_s2),
		.rot_amt_s2 (rot_amt_s2),
		.nan_hash_q (nan_hash_q),
		.inf_hash_q (inf_hash_q),
		.done_s4    (done),
		.hash_s4    (hash_word)
	);

	// Every accepted transaction yields exactly one result on done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted transaction produced no result after four cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result strobe without a matching transaction");

	// The exponent remainder stays a legal rotation amount.
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.valid |-> (rot_amt_s2 < EW'(HASH_BITS - 1) || rot_amt_s2 == EW'(HASH_BITS - 1)))
		else $error("rotation amount out of range");

	// A finite value never hashes to all ones.
	a_no_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && value_bits[62:52] != 11'h7FF, 4)) |-> hash_word != '1)
		else $error("finite value produced an all-ones hash");

	// A positive finite value hashes below 2^HASH_BITS.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !value_bits[63] && value_bits[62:52] != 11'h7FF, 4))
		|-> (hash_word >> HASH_BITS) == '0)
		else $error("positive finite hash exceeds the modulus width");

endmodule
